// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KFS_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("kfs assertion failed");

// Next-cycle implication, disabled during reset.
`define KFS_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("kfs assertion failed");

`endif

// ----- hdl/kfs_pkg.sv -----
// ---------------------------------------------------------------------------
// kfs_pkg
// Shared types, codes, microcode and arithmetic helpers of the Kalman step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package kfs_pkg;

   localparam int DATA_W    = 32;
   localparam int CFG_W     = 64;
   localparam int MEAS_W    = 31;
   localparam int MEM_DEPTH = 32;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int PC_W      = 7;

   // Register indexes
   localparam logic [2:0] REG_TRANS0 = 3'd0;
   localparam logic [2:0] REG_TRANS1 = 3'd1;
   localparam logic [2:0] REG_OBS    = 3'd2;
   localparam logic [2:0] REG_QNS0   = 3'd3;
   localparam logic [2:0] REG_QNS1   = 3'd4;
   localparam logic [2:0] REG_MEAS   = 3'd5;
   localparam logic [2:0] REG_INITX  = 3'd6;
   localparam logic [2:0] REG_INITP  = 3'd7;

   localparam logic [CFG_W-1:0]  RST_TRANS0 = 64'h0000_0000_0001_0000;
   localparam logic [CFG_W-1:0]  RST_TRANS1 = 64'h0001_0000_0000_0000;
   localparam logic [CFG_W-1:0]  RST_OBS    = 64'h0000_0000_0001_0000;
   localparam logic [CFG_W-1:0]  RST_QNS    = 64'h0;
   localparam logic [MEAS_W-1:0] RST_MEAS   = 31'h0001_0000;
   localparam logic [CFG_W-1:0]  RST_INITX  = 64'h0;
   localparam logic [CFG_W-1:0]  RST_INITP  = 64'h0100_0000_0000_0100;

   localparam logic [DATA_W-1:0] FX_ONE = 32'h0001_0000;
   localparam logic [DATA_W-1:0] FX_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] FX_MIN = 32'h8000_0000;

   typedef enum logic [3:0] {
      OP_MAC0     = 4'd0,  // acc = p
      OP_MAC      = 4'd1,  // acc = sat(acc + p)
      OP_MSU      = 4'd2,  // acc = sat(acc - p)
      OP_LOAD     = 4'd3,  // acc = a
      OP_ADD      = 4'd4,  // acc = sat(acc + a)
      OP_BRZ      = 4'd5,  // jump to singular path if acc is zero
      OP_RECIP    = 4'd6,  // dst = 2^32 / acc
      OP_END      = 4'd7,
      OP_END_SING = 4'd8
   } op_type;

   // Scratch codes (bit 5 clear) address the scratch RAM.
   typedef enum logic [5:0] {
      XP0 = 6'd0,   XP1 = 6'd1,
      FP00 = 6'd2,  FP01 = 6'd3,  FP10 = 6'd4,  FP11 = 6'd5,
      PP00 = 6'd6,  PP01 = 6'd7,  PP10 = 6'd8,  PP11 = 6'd9,
      YV = 6'd10,   HP0 = 6'd11,  HP1 = 6'd12,  INV = 6'd13,
      PHT0 = 6'd14, PHT1 = 6'd15, K0 = 6'd16,   K1 = 6'd17,
      IKH00 = 6'd18, IKH01 = 6'd19, IKH10 = 6'd20, IKH11 = 6'd21,
      E0 = 6'd32,   E1 = 6'd33,
      P00 = 6'd34,  P01 = 6'd35,  P10 = 6'd36,  P11 = 6'd37,
      F00 = 6'd38,  F01 = 6'd39,  F10 = 6'd40,  F11 = 6'd41,
      H0 = 6'd42,   H1 = 6'd43,
      Q00 = 6'd44,  Q01 = 6'd45,  Q10 = 6'd46,  Q11 = 6'd47,
      RN = 6'd48,   ZM = 6'd49,   ONE = 6'd50,  ZERO = 6'd51,
      NONE = 6'd52
   } src_type;

   typedef struct packed {
      op_type  op;
      src_type a;
      src_type b;
      src_type dst;
   } instr_type;

   typedef struct packed {
      logic latch_z;
      logic rd;
      logic mul;
      logic exe;
      logic div_start;
      logic div_wr;
      logic capture;
      logic sing;
   } cmd_type;

   typedef struct packed {
      logic acc_zero;
      logic div_done;
   } status_type;

   localparam logic [PC_W-1:0] SING_PC = 7'd63;

   function automatic instr_type mk(op_type op, src_type a, src_type b, src_type d);
      instr_type r;
      r.op  = op;
      r.a   = a;
      r.b   = b;
      r.dst = d;
      return r;
   endfunction

   // Microcode: predict, innovate, gain, update; singular path at SING_PC.
   function automatic instr_type rom(logic [PC_W-1:0] pc);
      instr_type r;
      unique case (pc)
         7'd0:  r = mk(OP_MAC0, F00, E0, NONE);
         7'd1:  r = mk(OP_MAC, F01, E1, XP0);
         7'd2:  r = mk(OP_MAC0, F10, E0, NONE);
         7'd3:  r = mk(OP_MAC, F11, E1, XP1);
         7'd4:  r = mk(OP_MAC0, F00, P00, NONE);
         7'd5:  r = mk(OP_MAC, F01, P10, FP00);
         7'd6:  r = mk(OP_MAC0, F00, P01, NONE);
         7'd7:  r = mk(OP_MAC, F01, P11, FP01);
         7'd8:  r = mk(OP_MAC0, F10, P00, NONE);
         7'd9:  r = mk(OP_MAC, F11, P10, FP10);
         7'd10: r = mk(OP_MAC0, F10, P01, NONE);
         7'd11: r = mk(OP_MAC, F11, P11, FP11);
         7'd12: r = mk(OP_MAC0, FP00, F00, NONE);
         7'd13: r = mk(OP_MAC, FP01, F01, NONE);
         7'd14: r = mk(OP_ADD, Q00, ZERO, PP00);
         7'd15: r = mk(OP_MAC0, FP00, F10, NONE);
         7'd16: r = mk(OP_MAC, FP01, F11, NONE);
         7'd17: r = mk(OP_ADD, Q01, ZERO, PP01);
         7'd18: r = mk(OP_MAC0, FP10, F00, NONE);
         7'd19: r = mk(OP_MAC, FP11, F01, NONE);
         7'd20: r = mk(OP_ADD, Q10, ZERO, PP10);
         7'd21: r = mk(OP_MAC0, FP10, F10, NONE);
         7'd22: r = mk(OP_MAC, FP11, F11, NONE);
         7'd23: r = mk(OP_ADD, Q11, ZERO, PP11);
         7'd24: r = mk(OP_LOAD, ZM, ZERO, NONE);
         7'd25: r = mk(OP_MSU, H0, XP0, NONE);
         7'd26: r = mk(OP_MSU, H1, XP1, YV);
         7'd27: r = mk(OP_MAC0, H0, PP00, NONE);
         7'd28: r = mk(OP_MAC, H1, PP10, HP0);
         7'd29: r = mk(OP_MAC0, H0, PP01, NONE);
         7'd30: r = mk(OP_MAC, H1, PP11, HP1);
         7'd31: r = mk(OP_MAC0, HP0, H0, NONE);
         7'd32: r = mk(OP_MAC, HP1, H1, NONE);
         7'd33: r = mk(OP_ADD, RN, ZERO, NONE);
         7'd34: r = mk(OP_BRZ, ZERO, ZERO, NONE);
         7'd35: r = mk(OP_RECIP, ZERO, ZERO, INV);
         7'd36: r = mk(OP_MAC0, PP00, H0, NONE);
         7'd37: r = mk(OP_MAC, PP01, H1, PHT0);
         7'd38: r = mk(OP_MAC0, PHT0, INV, K0);
         7'd39: r = mk(OP_LOAD, XP0, ZERO, NONE);
         7'd40: r = mk(OP_MAC, K0, YV, E0);
         7'd41: r = mk(OP_MAC0, PP10, H0, NONE);
         7'd42: r = mk(OP_MAC, PP11, H1, PHT1);
         7'd43: r = mk(OP_MAC0, PHT1, INV, K1);
         7'd44: r = mk(OP_LOAD, XP1, ZERO, NONE);
         7'd45: r = mk(OP_MAC, K1, YV, E1);
         7'd46: r = mk(OP_LOAD, ONE, ZERO, NONE);
         7'd47: r = mk(OP_MSU, K0, H0, IKH00);
         7'd48: r = mk(OP_LOAD, ZERO, ZERO, NONE);
         7'd49: r = mk(OP_MSU, K0, H1, IKH01);
         7'd50: r = mk(OP_LOAD, ZERO, ZERO, NONE);
         7'd51: r = mk(OP_MSU, K1, H0, IKH10);
         7'd52: r = mk(OP_LOAD, ONE, ZERO, NONE);
         7'd53: r = mk(OP_MSU, K1, H1, IKH11);
         7'd54: r = mk(OP_MAC0, IKH00, PP00, NONE);
         7'd55: r = mk(OP_MAC, IKH01, PP10, P00);
         7'd56: r = mk(OP_MAC0, IKH00, PP01, NONE);
         7'd57: r = mk(OP_MAC, IKH01, PP11, P01);
         7'd58: r = mk(OP_MAC0, IKH10, PP00, NONE);
         7'd59: r = mk(OP_MAC, IKH11, PP10, P10);
         7'd60: r = mk(OP_MAC0, IKH10, PP01, NONE);
         7'd61: r = mk(OP_MAC, IKH11, PP11, P11);
         7'd62: r = mk(OP_END, ZERO, ZERO, NONE);
         7'd63: r = mk(OP_LOAD, XP0, ZERO, E0);
         7'd64: r = mk(OP_LOAD, XP1, ZERO, E1);
         7'd65: r = mk(OP_LOAD, PP00, ZERO, P00);
         7'd66: r = mk(OP_LOAD, PP01, ZERO, P01);
         7'd67: r = mk(OP_LOAD, PP10, ZERO, P10);
         7'd68: r = mk(OP_LOAD, PP11, ZERO, P11);
         7'd69: r = mk(OP_END_SING, ZERO, ZERO, NONE);
         default: r = mk(OP_END, ZERO, ZERO, NONE);
      endcase
      return r;
   endfunction

   // Saturate a 33-bit sum to 32 bits.
   function automatic logic [DATA_W-1:0] sat33(logic [DATA_W:0] v);
      if (v[DATA_W] != v[DATA_W-1]) return v[DATA_W] ? FX_MIN : FX_MAX;
      return v[DATA_W-1:0];
   endfunction

endpackage

// ----- hdl/kalman_filter_step.sv -----
// ---------------------------------------------------------------------------
// kalman_filter_step
// Two-state linear Kalman filter, one predict/update pass per measurement.
// ---------------------------------------------------------------------------
// Each req beat carries one Q16.16 measurement; one rsp beat returns the
// updated estimate, the covariance diagonal and a singular flag. The block
// works on one measurement at a time: a microcoded sequencer drives a
// single 32x32 multiplier and a saturating accumulator through about sixty
// operations, most as read, multiply and execute steps, plus a restoring
// divider for 1/S; when S is zero the update is skipped. A finished result
// sits in an output register, so the next measurement is taken while it
// waits for rsp_tready. Configuration writes take effect at once; the user
// must make them only while the block is idle, as the block itself does not
// enforce it. Writing init_state or init_cov reloads the estimate or
// covariance.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kalman_filter_step
   import kfs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // measurement in
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [DATA_W-1:0]   req_tdata,   // [31:0] measurement
   // result out
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [4*DATA_W-1:0] rsp_tdata,   // estimate_0, estimate_1,
                                            // variance_0, variance_1
   output logic                rsp_tuser,   // [0] singular
   // register writes
   input  logic                csr_wen,
   input  logic [2:0]          csr_index,
   input  logic [CFG_W-1:0]    csr_wdata
);

   cmd_type    cmd;
   status_type status;
   instr_type  instr;

   // sequencer: microcode PC, handshakes, result valid
   kfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .instr      (instr)
   );

   // arithmetic, state and registers
   kfs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .instr     (instr),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ----- hdl/kfs_recip.sv -----
// ---------------------------------------------------------------------------
// kfs_recip
// Restoring divider: 2^32 / s, rounded half away from zero, saturated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kfs_recip
   import kfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   localparam int NUM_W = DATA_W + 1;
   localparam logic [5:0] ITER = 6'(NUM_W);

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [NUM_W-1:0]  trial;
   logic [DATA_W-1:0] mag_new;

   always_comb begin
      mag_new = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      trial   = {rem_ff, num_ff[NUM_W-1]};
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         mag_in  = mag_new;
         neg_in  = divisor[DATA_W-1];
         num_in  = {1'b1, {DATA_W{1'b0}}} + {1'b0, 1'b0, mag_new[DATA_W-1:1]};
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = ITER;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, mag_ff}) begin
            rem_in = DATA_W'(trial - {1'b0, mag_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
   end

   // quotient of 2^31 or more saturates
   always_comb begin
      if (quo_ff[NUM_W-1:DATA_W-1] != '0) quotient = neg_ff ? FX_MIN : FX_MAX;
      else if (neg_ff)                      quotient = ~quo_ff[DATA_W-1:0] + 1'b1;
      else                                  quotient = quo_ff[DATA_W-1:0];
   end

   assign done = done_ff;

endmodule

// ----- hdl/kfs_ctrl.sv -----
// ---------------------------------------------------------------------------
// kfs_ctrl
// Sequencer: steps the microcode, drives datapath commands, owns handshakes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kfs_ctrl
   import kfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd,
   output instr_type  instr
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_READ = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_EXE  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type       state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            sing_ff, sing_in;
   logic            valid_ff, valid_in;

   assign instr = rom(pc_ff);

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      sing_in  = sing_ff;
      cmd      = '0;
      cmd.sing = sing_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_z = 1'b1;
               pc_in       = '0;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            unique case (instr.op)
               OP_BRZ: begin
                  pc_in = status.acc_zero ? SING_PC : pc_ff + 1'b1;
               end
               OP_RECIP: begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end
               OP_END, OP_END_SING: begin
                  sing_in  = (instr.op == OP_END_SING);
                  state_in = ST_OUT;
               end
               default: begin
                  cmd.rd   = 1'b1;
                  state_in = ST_MUL;
               end
            endcase
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_EXE;
         end
         ST_EXE: begin
            cmd.exe  = 1'b1;
            pc_in    = pc_ff + 1'b1;
            state_in = ST_READ;
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.div_wr = 1'b1;
               pc_in      = pc_ff + 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_OUT: begin
            // result register is free or drains this cycle
            if (!valid_ff || rsp_tready) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      valid_in = cmd.capture ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         sing_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         sing_ff  <= sing_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

endmodule

// ----- hdl/kfs_dpath.sv -----
// ---------------------------------------------------------------------------
// kfs_dpath
// Datapath: config registers, filter state, scratch RAM, one multiplier,
// saturating accumulator, reciprocal unit and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kfs_dpath
   import kfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wen,
   input  logic [2:0]           csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic [DATA_W-1:0]    req_tdata,
   input  cmd_type              cmd,
   input  instr_type            instr,
   output status_type           status,
   output logic [4*DATA_W-1:0]  rsp_tdata,
   output logic                 rsp_tuser
);

   // configuration
   logic [CFG_W-1:0]  trans0_ff, trans1_ff, obs_ff, qns0_ff, qns1_ff;
   logic [MEAS_W-1:0] meas_ff;

   // filter state
   logic [DATA_W-1:0] e0_ff, e1_ff, p00_ff, p01_ff, p10_ff, p11_ff;

   logic [DATA_W-1:0] z_ff;
   logic [DATA_W-1:0] mem [0:MEM_DEPTH-1];
   logic [DATA_W-1:0] mem_a_ff, mem_b_ff, fix_a_ff, fix_b_ff;
   logic              a_mem_ff, b_mem_ff;
   logic signed [DATA_W-1:0]   opa, opb;
   logic signed [2*DATA_W-1:0] prod_ff, rnd;
   logic [DATA_W-1:0] opa_ff, sm, acc_ff, acc_in;
   logic [DATA_W-1:0] out_e0_ff, out_e1_ff, out_v0_ff, out_v1_ff;
   logic              out_sing_ff;
   logic [5:0]        a_code, b_code, d_code;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_wa;
   logic [DATA_W-1:0] mem_wd, div_q;
   logic              div_done;

   assign a_code = instr.a;
   assign b_code = instr.b;
   assign d_code = instr.dst;

   function automatic logic [DATA_W-1:0] fixed_val(src_type code);
      logic [DATA_W-1:0] v;
      unique case (code)
         E0:      v = e0_ff;
         E1:      v = e1_ff;
         P00:     v = p00_ff;
         P01:     v = p01_ff;
         P10:     v = p10_ff;
         P11:     v = p11_ff;
         F00:     v = trans0_ff[DATA_W-1:0];
         F01:     v = trans0_ff[CFG_W-1:DATA_W];
         F10:     v = trans1_ff[DATA_W-1:0];
         F11:     v = trans1_ff[CFG_W-1:DATA_W];
         H0:      v = obs_ff[DATA_W-1:0];
         H1:      v = obs_ff[CFG_W-1:DATA_W];
         Q00:     v = qns0_ff[DATA_W-1:0];
         Q01:     v = qns0_ff[CFG_W-1:DATA_W];
         Q10:     v = qns1_ff[DATA_W-1:0];
         Q11:     v = qns1_ff[CFG_W-1:DATA_W];
         RN:      v = {1'b0, meas_ff};
         ZM:      v = z_ff;
         ONE:     v = FX_ONE;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q8.8 word widened to Q16.16
   function automatic logic [DATA_W-1:0] widen(logic [15:0] w);
      return {{8{w[15]}}, w, 8'h00};
   endfunction

   // operand fetch
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (cmd.rd) begin
         mem_a_ff <= mem[a_code[MEM_AW-1:0]];
         mem_b_ff <= mem[b_code[MEM_AW-1:0]];
         fix_a_ff <= fixed_val(instr.a);
         fix_b_ff <= fixed_val(instr.b);
         a_mem_ff <= ~a_code[5];
         b_mem_ff <= ~b_code[5];
      end
      if (cmd.latch_z) z_ff <= req_tdata;
   end

   // multiply
   assign opa = a_mem_ff ? mem_a_ff : fix_a_ff;
   assign opb = b_mem_ff ? mem_b_ff : fix_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= opa * opb;
         opa_ff  <= opa;
      end
   end

   // round half up, shift to Q16.16, saturate, then accumulate
   always_comb begin
      rnd = prod_ff + 64'sd32768;
      if (rnd[63:47] == {17{rnd[63]}}) sm = rnd[47:16];
      else                             sm = rnd[63] ? FX_MIN : FX_MAX;
      unique case (instr.op)
         OP_MAC0: acc_in = sm;
         OP_MAC:  acc_in = sat33({acc_ff[DATA_W-1], acc_ff} + {sm[DATA_W-1], sm});
         OP_MSU:  acc_in = sat33({acc_ff[DATA_W-1], acc_ff} - {sm[DATA_W-1], sm});
         OP_LOAD: acc_in = opa_ff;
         OP_ADD:  acc_in = sat33({acc_ff[DATA_W-1], acc_ff} + {opa_ff[DATA_W-1], opa_ff});
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.exe) acc_ff <= acc_in;
   end

   kfs_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (acc_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // scratch write-back
   always_comb begin
      mem_we = (cmd.exe && !d_code[5]) || cmd.div_wr;
      mem_wa = d_code[MEM_AW-1:0];
      mem_wd = cmd.div_wr ? div_q : acc_in;
   end

   // configuration and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         trans0_ff <= RST_TRANS0;
         trans1_ff <= RST_TRANS1;
         obs_ff    <= RST_OBS;
         qns0_ff   <= RST_QNS;
         qns1_ff   <= RST_QNS;
         meas_ff   <= RST_MEAS;
         e0_ff     <= RST_INITX[DATA_W-1:0];
         e1_ff     <= RST_INITX[CFG_W-1:DATA_W];
         p00_ff    <= widen(RST_INITP[15:0]);
         p01_ff    <= widen(RST_INITP[31:16]);
         p10_ff    <= widen(RST_INITP[47:32]);
         p11_ff    <= widen(RST_INITP[63:48]);
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_TRANS0: trans0_ff <= csr_wdata;
            REG_TRANS1: trans1_ff <= csr_wdata;
            REG_OBS:    obs_ff    <= csr_wdata;
            REG_QNS0:   qns0_ff   <= csr_wdata;
            REG_QNS1:   qns1_ff   <= csr_wdata;
            REG_MEAS:   meas_ff   <= csr_wdata[MEAS_W-1:0];
            REG_INITX: begin
               e0_ff <= csr_wdata[DATA_W-1:0];
               e1_ff <= csr_wdata[CFG_W-1:DATA_W];
            end
            REG_INITP: begin
               p00_ff <= widen(csr_wdata[15:0]);
               p01_ff <= widen(csr_wdata[31:16]);
               p10_ff <= widen(csr_wdata[47:32]);
               p11_ff <= widen(csr_wdata[63:48]);
            end
            default: ;
         endcase
      end else if (cmd.exe) begin
         unique case (instr.dst)
            E0:      e0_ff  <= acc_in;
            E1:      e1_ff  <= acc_in;
            P00:     p00_ff <= acc_in;
            P01:     p01_ff <= acc_in;
            P10:     p10_ff <= acc_in;
            P11:     p11_ff <= acc_in;
            default: ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         out_e0_ff   <= e0_ff;
         out_e1_ff   <= e1_ff;
         out_v0_ff   <= p00_ff;
         out_v1_ff   <= p11_ff;
         out_sing_ff <= cmd.sing;
      end
   end

   assign rsp_tdata = {out_v1_ff, out_v0_ff, out_e1_ff, out_e0_ff};
   assign rsp_tuser = out_sing_ff;

   assign status.acc_zero = (acc_ff == '0);
   assign status.div_done = div_done;

endmodule

// ----- hdl/kfs_checker.sv -----
// ---------------------------------------------------------------------------
// kfs_checker
// Port-level checks of the Kalman step, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kfs_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tuser
);

   // a stalled result beat holds
   `KFS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // one measurement at a time
   `KFS_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

   // a new result appears only as the pass finishes
   `KFS_ASSERT_IMP(a_rsp_from_pass, clock, reset, $rose(rsp_tvalid), $past(!req_tready))

endmodule

bind kalman_filter_step kfs_checker u_kfs_checker (.*);

// ----- test/kalman_filter_step_tb.sv -----
// ---------------------------------------------------------------------------
// kalman_filter_step_tb
// Self-checking bench for the two-state Kalman filter step.
// ---------------------------------------------------------------------------
// A behavioural filter in the bench tracks estimate and covariance beside
// the block and predicts every response beat, which is then checked field
// by field in arrival order. Directed tests cover field extremes, the
// singular path, init reloads and odd register values. A long random part
// runs under several settings. Both sides idle in random bursts, except
// in the final phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kalman_filter_step_tb;
   import kfs_pkg::*;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata;     // [31:0] measurement
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [4*DATA_W-1:0] rsp_tdata;     // est0, est1, var0, var1 from bit 0
   logic                rsp_tuser;     // [0] singular
   logic                csr_wen;
   logic [2:0]          csr_index;
   logic [CFG_W-1:0]    csr_wdata;

   typedef struct packed {
      logic [31:0] var1;
      logic [31:0] var0;
      logic [31:0] est1;
      logic [31:0] est0;
      logic        sing;
   } fix_result_type;

   fix_result_type pending_q[$];
   int          mismatches;
   longint      cycles;
   bit          idle_on;

   // Bench copy of the register file and filter state.
   logic [63:0] regs[8];
   int          x_est[2];
   int          p_cov[2][2];

   kalman_filter_step u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Q16.16 arithmetic, saturating to 32 bits.
   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
   endfunction

   function automatic int fx_add(int a, int b);
      return clamp32(longint'(a) + longint'(b));
   endfunction

   function automatic int fx_sub(int a, int b);
      return clamp32(longint'(a) - longint'(b));
   endfunction

   // Arithmetic shift of the product rounds half toward plus infinity.
   function automatic int fx_mul(int a, int b);
      longint p;
      p = longint'(a) * longint'(b) + 64'sd32768;
      return clamp32(p >>> 16);
   endfunction

   function automatic int fx_recip(int s);
      longint unsigned mag, q;
      longint r;
      mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
      q = ((64'd1 << 32) + mag / 2) / mag;
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      r = (s < 0) ? -longint'(q) : longint'(q);
      return clamp32(r);
   endfunction

   function automatic int half(logic [63:0] v, int i);
      return i ? int'(v[63:32]) : int'(v[31:0]);
   endfunction

   // Mirror of a register write, including the reloads of init_state/cov.
   task automatic mirror_write(logic [2:0] idx, logic [63:0] val);
      if (idx == REG_MEAS) val = val & 64'h7FFF_FFFF;
      regs[idx] = val;
      if (idx == REG_INITX) begin
         for (int i = 0; i < 2; i++) x_est[i] = half(val, i);
      end
      if (idx == REG_INITP) begin
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
               p_cov[i][j] = int'(signed'(val[16*(2*i+j) +: 16])) * 256;
      end
   endtask

   // One predict/update pass for measurement z; returns the expected beat.
   function automatic fix_result_type filter_pass(int z);
      int f[2][2], q[2][2], h[2];
      int xp[2], fp[2][2], pp[2][2], hp[2], pht[2], kg[2], ikh[2][2], pn[2][2];
      int y, s, inv;
      fix_result_type r;
      for (int i = 0; i < 2; i++) begin
         f[0][i] = half(regs[REG_TRANS0], i);
         f[1][i] = half(regs[REG_TRANS1], i);
         h[i]    = half(regs[REG_OBS], i);
         q[0][i] = half(regs[REG_QNS0], i);
         q[1][i] = half(regs[REG_QNS1], i);
         xp[i] = 0; hp[i] = 0; pht[i] = 0;
         for (int j = 0; j < 2; j++) begin
            fp[i][j] = 0; pp[i][j] = 0; pn[i][j] = 0;
         end
      end
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) begin
            xp[i] = fx_add(xp[i], fx_mul(f[i][j], x_est[j]));
            for (int k = 0; k < 2; k++)
               fp[i][j] = fx_add(fp[i][j], fx_mul(f[i][k], p_cov[k][j]));
         end
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) begin
            for (int k = 0; k < 2; k++)
               pp[i][j] = fx_add(pp[i][j], fx_mul(fp[i][k], f[j][k]));
            pp[i][j] = fx_add(pp[i][j], q[i][j]);
         end
      y = z;
      for (int i = 0; i < 2; i++) y = fx_sub(y, fx_mul(h[i], xp[i]));
      s = 0;
      for (int j = 0; j < 2; j++) begin
         for (int i = 0; i < 2; i++) hp[j] = fx_add(hp[j], fx_mul(h[i], pp[i][j]));
         s = fx_add(s, fx_mul(hp[j], h[j]));
      end
      s = fx_add(s, int'(regs[REG_MEAS][30:0]));
      r.sing = (s == 0);
      if (r.sing) begin
         x_est = xp;
         p_cov = pp;
      end else begin
         inv = fx_recip(s);
         for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) pht[i] = fx_add(pht[i], fx_mul(pp[i][j], h[j]));
            kg[i] = fx_mul(pht[i], inv);
            x_est[i] = fx_add(xp[i], fx_mul(kg[i], y));
         end
         for (int i = 0; i < 2; i++)
            for (int k = 0; k < 2; k++)
               ikh[i][k] = fx_sub((i == k) ? 65536 : 0, fx_mul(kg[i], h[k]));
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
               for (int k = 0; k < 2; k++)
                  pn[i][j] = fx_add(pn[i][j], fx_mul(ikh[i][k], pp[k][j]));
         p_cov = pn;
      end
      r.est0 = x_est[0];
      r.est1 = x_est[1];
      r.var0 = p_cov[0][0];
      r.var1 = p_cov[1][1];
      return r;
   endfunction

   // Send one measurement beat, with an optional idle burst before it.
   // Returns at the accepting edge; tvalid stays high until the next call's idle burst or a release drops it.
   task automatic send_meas(logic [31:0] z);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= z;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_q.push_back(filter_pass(int'(z)));
   endtask

   // Release the request, drain, then write a register while the block is idle.
   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen   <= 1'b0;
      mirror_write(idx, val);
   endtask

   function automatic logic [63:0] pair(int a, int b);
      return {b[31:0], a[31:0]};
   endfunction

   // Small Q16.16 value, around +-4.0, to keep the filter well behaved.
   function automatic int small_fx();
      return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
   endfunction

   function automatic logic [63:0] rand_cov();
      logic [15:0] d0, d1, od;
      d0 = 16'($urandom_range(0, 16'h0800));
      d1 = 16'($urandom_range(0, 16'h0800));
      od = 16'($urandom_range(0, 16'h0100) - 16'h0080);
      return {d1, od, od, d0};
   endfunction

   // Response side: random stalls and field-by-field check.
   initial begin
      fix_result_type want;
      fix_result_type got;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata, rsp_tuser};
            if (pending_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected beat %h", got);
            end else begin
               want = pending_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: est %h %h var %h %h sing %b, exp %h %h %h %h %b",
                              got.est0, got.est1, got.var0, got.var1, got.sing,
                              want.est0, want.est1, want.var0, want.var1, want.sing);
               end
            end
         end
      end
   end

   // Watchdog: ends the run with FAIL if it hangs.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 64'd3_000_000) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic test_extremes();
      send_meas(32'h7FFF_FFFF);
      send_meas(32'h8000_0000);
      send_meas(32'h0000_0000);
      send_meas(32'hFFFF_FFFF);
      send_meas(32'h0001_0000);
      send_meas(32'h5555_5555);
      send_meas(32'hAAAA_AAAA);
   endtask

   // S is zero: R = 0 and zero covariance, then a negative-sum case.
   task automatic test_singular();
      write_reg(REG_MEAS, 64'hFFFF_FFFF_0000_0000);   // upper bits dropped
      write_reg(REG_INITP, 64'h0);
      send_meas(32'h0003_0000);
      send_meas(32'hFFFD_0000);
      write_reg(REG_INITP, 64'h0100_0000_0000_0100);
      write_reg(REG_OBS, pair(32'sh0001_0000, 32'sh0001_0000));
      write_reg(REG_INITP, {16'h0100, 16'hFF00, 16'hFF00, 16'h0100});
      send_meas(32'h0001_0000);
      write_reg(REG_MEAS, 64'h7FFF_FFFF);
      send_meas(32'h7FFF_0000);
   endtask

   // Extreme register contents drive saturation everywhere.
   task automatic test_saturation();
      write_reg(REG_TRANS0, 64'h7FFF_FFFF_8000_0000);
      write_reg(REG_TRANS1, 64'h8000_0000_7FFF_FFFF);
      write_reg(REG_QNS0, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_QNS1, 64'h7FFF_FFFF_0000_0001);
      write_reg(REG_INITX, 64'h8000_0000_7FFF_FFFF);
      write_reg(REG_INITP, 64'h7FFF_8000_8000_7FFF);
      send_meas(32'h8000_0000);
      send_meas(32'h7FFF_FFFF);
      write_reg(REG_INITP, 64'hFFFF_FFFF_FFFF_FFFF);
      send_meas(32'h1234_5678);
   endtask

   task automatic setup_random(bit wild);
      write_reg(REG_TRANS0, pair(32'sh0001_0000 + small_fx() / 8, small_fx() / 4));
      write_reg(REG_TRANS1, pair(small_fx() / 8, 32'sh0001_0000 + small_fx() / 8));
      write_reg(REG_OBS, pair(small_fx() / 2, small_fx() / 4));
      write_reg(REG_QNS0, pair($urandom_range(0, 32'h4000), 0));
      write_reg(REG_QNS1, pair(0, $urandom_range(0, 32'h4000)));
      write_reg(REG_MEAS, wild ? {$urandom, $urandom} : 64'($urandom_range(1, 32'h0004_0000)));
      write_reg(REG_INITX, pair(small_fx(), small_fx()));
      write_reg(REG_INITP, wild ? {$urandom, $urandom} : rand_cov());
   endtask

   task automatic test_random(int phases, int per_phase);
      for (int p = 0; p < phases; p++) begin
         setup_random(p % 5 == 4);
         for (int n = 0; n < per_phase; n++)
            send_meas(($urandom_range(0, 9) == 0) ? $urandom : small_fx() * 4);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      mismatches = 0;
      idle_on    = 1'b1;
      regs[REG_TRANS0] = RST_TRANS0;
      regs[REG_TRANS1] = RST_TRANS1;
      regs[REG_OBS]    = RST_OBS;
      regs[REG_QNS0]   = RST_QNS;
      regs[REG_QNS1]   = RST_QNS;
      regs[REG_MEAS]   = 64'(RST_MEAS);
      regs[REG_INITX]  = RST_INITX;
      mirror_write(REG_INITP, RST_INITP);
      x_est[0] = 0;
      x_est[1] = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_singular();
      test_saturation();
      test_random(25, 56);
      // final phase runs with no idling on either side
      idle_on = 1'b0;
      test_random(5, 50);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (mismatches == 0 && pending_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
